// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both forms sample on the rising edge of clk
// and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dblg_pkg.sv =====
package dblg_pkg;

  // Control and status of the growth engine, seen by the top level.
  typedef struct packed {
    logic busy;      // Engine is walking the frame.
    logic done;      // One-cycle pulse when the last pass has been written back.
    logic side;      // Back buffer that holds the current back depths.
    logic rd_en;     // Engine reads the current back buffer.
    logic front_rd;  // Engine reads the front store.
    logic wr_en;     // Engine writes a grown depth.
    logic wr_bank;   // Back buffer that the engine write goes to.
  } grow_ctrl_t;

endpackage

// ===== rtl/core/dblg_grow.sv =====
`include "assert_macros.svh"

module dblg_grow #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int DEPTH_BITS = 16,
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int WID_W  = $clog2(MAX_WIDTH + 1),
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [WID_W-1:0]       width,
  input  logic [HGT_W-1:0]       height,
  input  logic [7:0]             passes,
  input  logic [DEPTH_BITS-1:0]  snap0,
  input  logic [DEPTH_BITS-1:0]  snap1,
  input  logic [DEPTH_BITS-1:0]  front,
  output dblg_pkg::grow_ctrl_t   ctrl,
  output logic [ADDR_W-1:0]      rd_addr,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic [DEPTH_BITS-1:0]  wr_data
);

  import dblg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} state_t;

  // Read order for one target pixel: its own snapshot, then the sources in raster order.
  typedef enum logic [2:0] {SLOT_CENTER, SLOT_UP, SLOT_LEFT, SLOT_RIGHT, SLOT_DOWN} slot_t;

  state_t              state;
  logic                side;
  logic                done;
  logic [7:0]          pass_left;
  logic [HGT_W-1:0]    row;
  logic [WID_W-1:0]    col;
  logic [ADDR_W-1:0]   pix;
  slot_t               slot;
  slot_t               slot_next;

  // Arrival stage: the request issued in the previous cycle and its read data.
  logic                a_valid;
  slot_t               a_slot;
  logic                a_ok;
  logic                a_rbank;
  logic                a_wbank;
  logic [ADDR_W-1:0]   a_addr;
  logic [DEPTH_BITS-1:0] ob;
  logic [DEPTH_BITS-1:0] of;
  logic [DEPTH_BITS-1:0] best;

  logic [ADDR_W-1:0]   issue_addr;
  logic                issue_ok;
  logic [WID_W:0]      cx;
  logic [WID_W:0]      wx;
  logic [HGT_W:0]      rx;
  logic [HGT_W:0]      hx;
  logic                col_in;
  logic                col_ge2;
  logic                col_le3;
  logic                row_mid;
  logic                row_ge2;
  logic                row_le3;
  logic                col_last;
  logic                row_last;
  logic [DEPTH_BITS-1:0] d;
  logic                qual;
  logic [DEPTH_BITS-1:0] pick;

  // Position tests that tell which neighbors of the target are interior sources.
  always_comb begin
    cx       = {1'b0, col};
    wx       = {1'b0, width};
    rx       = {1'b0, row};
    hx       = {1'b0, height};
    col_ge2  = cx >= (WID_W + 1)'(2);
    col_in   = (col != '0) && (cx + (WID_W + 1)'(2) <= wx);
    col_le3  = cx + (WID_W + 1)'(3) <= wx;
    row_ge2  = rx >= (HGT_W + 1)'(2);
    row_mid  = (row != '0) && (rx + (HGT_W + 1)'(2) <= hx);
    row_le3  = rx + (HGT_W + 1)'(3) <= hx;
    col_last = col == width - WID_W'(1);
    row_last = row == height - HGT_W'(1);
  end

  // Address of the snapshot entry read in the current slot.
  always_comb begin
    unique case (slot)
      SLOT_CENTER: begin
        issue_addr = pix;
        issue_ok   = 1'b1;
        slot_next  = SLOT_UP;
      end
      SLOT_UP: begin
        issue_addr = pix - ADDR_W'(width);
        issue_ok   = row_ge2 && col_in;
        slot_next  = SLOT_LEFT;
      end
      SLOT_LEFT: begin
        issue_addr = pix - ADDR_W'(1);
        issue_ok   = col_ge2 && row_mid;
        slot_next  = SLOT_RIGHT;
      end
      SLOT_RIGHT: begin
        issue_addr = pix + ADDR_W'(1);
        issue_ok   = col_le3 && row_mid;
        slot_next  = SLOT_DOWN;
      end
      SLOT_DOWN: begin
        issue_addr = pix + ADDR_W'(width);
        issue_ok   = row_le3 && col_in;
        slot_next  = SLOT_CENTER;
      end
      default: begin
        issue_addr = pix;
        issue_ok   = 1'b0;
        slot_next  = SLOT_CENTER;
      end
    endcase
  end

  // A source wins when it beats the target's snapshot and its front depth.
  always_comb begin
    d    = a_rbank ? snap1 : snap0;
    qual = a_ok && (ob < d) && ((of == '0) || (of < d));
    pick = qual ? d : best;
  end

  always_comb begin
    ctrl.busy     = state != S_IDLE;
    ctrl.done     = done;
    ctrl.side     = side;
    ctrl.rd_en    = (state == S_SCAN) && issue_ok;
    ctrl.front_rd = (state == S_SCAN) && (slot == SLOT_CENTER);
    ctrl.wr_en    = a_valid && (a_slot == SLOT_DOWN);
    ctrl.wr_bank  = a_wbank;
    rd_addr       = issue_addr;
    wr_addr       = a_addr;
    wr_data       = pick;
  end

  // Pass sequencer: walks every frame pixel, up to five snapshot reads per pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      side      <= 1'b0;
      done      <= 1'b0;
      a_valid   <= 1'b0;
      pass_left <= '0;
      row       <= '0;
      col       <= '0;
      pix       <= '0;
      slot      <= SLOT_CENTER;
    end else begin
      done    <= 1'b0;
      a_valid <= state == S_SCAN;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (passes == '0) begin
              done <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
            pass_left <= passes;
            row       <= '0;
            col       <= '0;
            pix       <= '0;
            slot      <= SLOT_CENTER;
          end
        end
        S_SCAN: begin
          slot <= slot_next;
          if (slot == SLOT_DOWN) begin
            if (col_last && row_last) begin
              // End of a pass: the buffer just written becomes the snapshot.
              row  <= '0;
              col  <= '0;
              pix  <= '0;
              side <= ~side;
              if (pass_left == 8'd1) begin
                state <= S_DRAIN;
              end else begin
                pass_left <= pass_left - 8'd1;
              end
            end else if (col_last) begin
              col <= '0;
              row <= row + HGT_W'(1);
              pix <= pix + ADDR_W'(1);
            end else begin
              col <= col + WID_W'(1);
              pix <= pix + ADDR_W'(1);
            end
          end
        end
        S_DRAIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Arrival stage payload and the running choice for the current target.
  always_ff @(posedge clk) begin
    a_slot  <= slot;
    a_ok    <= issue_ok;
    a_rbank <= side;
    a_wbank <= ~side;
    a_addr  <= pix;
    if (a_valid) begin
      if (a_slot == SLOT_CENTER) begin
        ob   <= d;
        of   <= front;
        best <= d;
      end else begin
        best <= pick;
      end
    end
  end

  `ASSERT_NEXT(a_done_pulse, done, !done, "growth done held longer than one cycle")
  `ASSERT_IMPL(a_start_idle, start, state == S_IDLE, "growth started while engine busy")
  `ASSERT_IMPL(a_down_after_right, a_valid && (a_slot == SLOT_DOWN),
               $past(a_valid && (a_slot == SLOT_RIGHT)), "write back out of slot order")

endmodule

// ===== rtl/core/depth_back_layer_grow.sv =====
// Channel   Direction  Handshake             Contents
// in        request    in_valid / in_stall   mode, pixel_index, front_depth, is_edge
// out       result     out_valid / out_stall back_depth, run_done
// cfg       write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Write and read requests flow at one per cycle while no run is active and the output
// does not stall; each result passes the read-data stage and the output register. A run
// does up to five reads per pixel through the single read port of the back-depth buffer.
// Reset clears control and registers only; the stores are undefined until written.
// A stalled output holds one result and one more request in flight, then stalls input.
`include "assert_macros.svh"

module depth_back_layer_grow #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int DEPTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [13:0] pixel_index,
  input  logic [15:0] front_depth,
  input  logic        is_edge,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] back_depth,
  output logic        run_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  import dblg_pkg::*;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);
  localparam int NPIX_W    = WID_W + HGT_W;
  localparam int CMP_W     = (NPIX_W > 14) ? NPIX_W : 14;
  localparam int WCMP      = (WID_W > 8) ? WID_W : 8;
  localparam int HCMP      = (HGT_W > 8) ? HGT_W : 8;
  localparam int WIDTH_RST = (MAX_WIDTH < 128) ? MAX_WIDTH : 128;
  localparam int HGT_RST   = (MAX_HEIGHT < 128) ? MAX_HEIGHT : 128;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PASSES = 2'd2;

  typedef enum logic [1:0] {R_IDLE, R_WAIT, R_BUSY} run_state_t;

  logic [WID_W-1:0]      frame_width;
  logic [HGT_W-1:0]      frame_height;
  logic [7:0]            pass_count;
  logic [WID_W-1:0]      width_next;
  logic [HGT_W-1:0]      height_next;

  logic [DEPTH_BITS-1:0] front_mem [MEM_DEPTH];
  logic [DEPTH_BITS-1:0] back_mem0 [MEM_DEPTH];
  logic [DEPTH_BITS-1:0] back_mem1 [MEM_DEPTH];
  logic [DEPTH_BITS-1:0] front_q;
  logic [DEPTH_BITS-1:0] back_q0;
  logic [DEPTH_BITS-1:0] back_q1;

  grow_ctrl_t            ctrl;
  logic [ADDR_W-1:0]     seq_rd_addr;
  logic [ADDR_W-1:0]     seq_wr_addr;
  logic [DEPTH_BITS-1:0] seq_wr_data;
  logic                  start;

  run_state_t            rstate;
  logic                  p1_valid;
  logic                  p1_read;
  logic                  p1_bank;
  logic                  p1_done;

  logic                  accept;
  logic                  adv;
  logic [NPIX_W-1:0]     npix;
  logic                  in_frame;
  logic [ADDR_W-1:0]     item_addr;
  logic                  item_wr;
  logic                  item_rd;
  logic [DEPTH_BITS-1:0] item_front;
  logic [DEPTH_BITS-1:0] item_back;
  logic                  we0;
  logic                  we1;
  logic                  re0;
  logic                  re1;
  logic [ADDR_W-1:0]     wa;
  logic [DEPTH_BITS-1:0] wd;
  logic [ADDR_W-1:0]     ra;
  logic [15:0]           p1_back;

  // Frame sizes saturate into their legal range when written.
  always_comb begin
    if (cfg_data < 8'd3) begin
      width_next = WID_W'(3);
    end else if (WCMP'(cfg_data) > WCMP'(MAX_WIDTH)) begin
      width_next = WID_W'(MAX_WIDTH);
    end else begin
      width_next = WID_W'(cfg_data);
    end
    if (cfg_data < 8'd3) begin
      height_next = HGT_W'(3);
    end else if (HCMP'(cfg_data) > HCMP'(MAX_HEIGHT)) begin
      height_next = HGT_W'(MAX_HEIGHT);
    end else begin
      height_next = HGT_W'(cfg_data);
    end
  end

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WID_W'(WIDTH_RST);
      frame_height <= HGT_W'(HGT_RST);
      pass_count   <= 8'd29;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  frame_width  <= width_next;
        CFG_HEIGHT: frame_height <= height_next;
        CFG_PASSES: pass_count   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request decode and frame bounds check.
  always_comb begin
    adv        = !out_valid || !out_stall;
    in_stall   = (rstate != R_IDLE) || (p1_valid && !adv);
    accept     = in_valid && !in_stall;
    npix       = NPIX_W'(frame_width) * NPIX_W'(frame_height);
    in_frame   = CMP_W'(pixel_index) < CMP_W'(npix);
    item_addr  = ADDR_W'(pixel_index);
    item_wr    = accept && (mode == MODE_WRITE) && in_frame;
    item_rd    = accept && (mode == MODE_READ) && in_frame;
    item_front = DEPTH_BITS'(front_depth);
    item_back  = is_edge ? item_front : '0;
    start      = (rstate == R_WAIT) && !p1_valid;
  end

  // Memory port steering between requests and the growth engine.
  always_comb begin
    we0 = (item_wr && !ctrl.side) || (ctrl.wr_en && !ctrl.wr_bank);
    we1 = (item_wr && ctrl.side) || (ctrl.wr_en && ctrl.wr_bank);
    wa  = ctrl.wr_en ? seq_wr_addr : item_addr;
    wd  = ctrl.wr_en ? seq_wr_data : item_back;
    re0 = (item_rd || ctrl.rd_en) && !ctrl.side;
    re1 = (item_rd || ctrl.rd_en) && ctrl.side;
    ra  = ctrl.rd_en ? seq_rd_addr : item_addr;
  end

  // Front depth store.
  always_ff @(posedge clk) begin
    if (item_wr) begin
      front_mem[item_addr] <= item_front;
    end
    if (ctrl.front_rd) begin
      front_q <= front_mem[seq_rd_addr];
    end
  end

  // Back depth buffers; one holds the pass snapshot while the other is rebuilt.
  always_ff @(posedge clk) begin
    if (we0) begin
      back_mem0[wa] <= wd;
    end
    if (re0) begin
      back_q0 <= back_mem0[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      back_mem1[wa] <= wd;
    end
    if (re1) begin
      back_q1 <= back_mem1[ra];
    end
  end

  dblg_grow #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_grow (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .width   (frame_width),
    .height  (frame_height),
    .passes  (pass_count),
    .snap0   (back_q0),
    .snap1   (back_q1),
    .front   (front_q),
    .ctrl    (ctrl),
    .rd_addr (seq_rd_addr),
    .wr_addr (seq_wr_addr),
    .wr_data (seq_wr_data)
  );

  assign p1_back = p1_read ? 16'(p1_bank ? back_q1 : back_q0) : 16'd0;

  // Run control, the read-data stage and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rstate    <= R_IDLE;
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p1_valid && adv) begin
        out_valid  <= 1'b1;
        back_depth <= p1_back;
        run_done   <= p1_done;
      end else if (adv) begin
        out_valid <= 1'b0;
      end

      if (accept && (mode != MODE_RUN)) begin
        p1_valid <= 1'b1;
        p1_read  <= (mode == MODE_READ) && in_frame;
        p1_bank  <= ctrl.side;
        p1_done  <= 1'b0;
      end else if (ctrl.done) begin
        p1_valid <= 1'b1;
        p1_read  <= 1'b0;
        p1_done  <= 1'b1;
      end else if (adv) begin
        p1_valid <= 1'b0;
      end

      unique case (rstate)
        R_IDLE: begin
          if (accept && (mode == MODE_RUN)) begin
            rstate <= R_WAIT;
          end
        end
        R_WAIT: begin
          if (!p1_valid) begin
            rstate <= R_BUSY;
          end
        end
        R_BUSY: begin
          if (ctrl.done) begin
            rstate <= R_IDLE;
          end
        end
        default: begin
          rstate <= R_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_run_waits, accept && (mode == MODE_RUN), rstate == R_WAIT,
               "run request did not enter the wait state")
  `ASSERT_NEXT(a_done_loads, ctrl.done, p1_valid && p1_done, "run result not queued")
  `ASSERT_IMPL(a_busy_stalls, ctrl.busy, in_stall, "request taken while growth runs")

endmodule

// ===== tb/depth_back_layer_grow_test.sv =====
module depth_back_layer_grow_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_MAX = 128;
  localparam int STORE_SIZE = FRAME_MAX * FRAME_MAX;
  // The widest and the tallest frame take about a thousand requests; small frames make
  // up the rest.
  localparam int REQ_TARGET = 1800;
  // The slowest legal run spends most of its time in growth walks.
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef enum bit [1:0] {
    MODE_WRITE = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  typedef enum bit [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_PASSES = 2'd2,
    REG_UNUSED = 2'd3
  } reg_e;

  typedef struct {
    mode_e     mode;
    bit [13:0] pix;
    bit [15:0] front;
    bit        seed;
  } pix_req_t;

  typedef struct {
    bit [15:0] depth;
    bit        done;
  } readout_t;

  // Tracks the front and back depth maps and the registers, and checks readouts.
  class depth_scoreboard;
    bit [15:0] front_mem [STORE_SIZE];
    bit [15:0] back_mem [STORE_SIZE];
    bit [15:0] snap_mem [STORE_SIZE];
    bit [7:0]  width_reg;
    bit [7:0]  height_reg;
    bit [7:0]  passes_reg;
    readout_t  due_readouts [$];
    int        errors;

    function new();
      width_reg = 8'd128;
      height_reg = 8'd128;
      passes_reg = 8'd29;
      errors = 0;
    endfunction

    function int clamp_dim(bit [7:0] v);
      if (v < 3) return 3;
      if (v > FRAME_MAX) return FRAME_MAX;
      return int'(v);
    endfunction

    function int frame_pixels();
      return clamp_dim(width_reg) * clamp_dim(height_reg);
    endfunction

    function void write_reg(reg_e idx, bit [7:0] v);
      case (idx)
        REG_WIDTH: width_reg = v;
        REG_HEIGHT: height_reg = v;
        REG_PASSES: passes_reg = v;
        default: ;
      endcase
    endfunction

    // A target takes the offered depth if both its old back depth and its front
    // depth are empty or shallower than the offer.
    function void offer_depth(int t, bit [15:0] d);
      if ((snap_mem[t] == 0 || snap_mem[t] < d) && (front_mem[t] == 0 || front_mem[t] < d))
        back_mem[t] = d;
    endfunction

    // One growth pass; only interior pixels act as sources, all reads use the snapshot.
    function void grow_pass(int w, int h);
      int i;
      int r;
      int c;
      int p;
      bit [15:0] d;
      for (i = 0; i < w * h; i++) snap_mem[i] = back_mem[i];
      for (r = 1; r < h - 1; r++) begin
        for (c = 1; c < w - 1; c++) begin
          p = r * w + c;
          d = snap_mem[p];
          if (d != 0) begin
            offer_depth(p - 1, d);
            offer_depth(p + 1, d);
            offer_depth(p - w, d);
            offer_depth(p + w, d);
          end
        end
      end
    endfunction

    function void note_request(pix_req_t rq);
      int w;
      int h;
      int k;
      readout_t ro;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      ro.depth = 16'd0;
      ro.done = 1'b0;
      case (rq.mode)
        MODE_WRITE: begin
          if (rq.pix < w * h) begin
            front_mem[rq.pix] = rq.front;
            back_mem[rq.pix] = rq.seed ? rq.front : 16'd0;
          end
        end
        MODE_RUN: begin
          for (k = 0; k < passes_reg; k++) grow_pass(w, h);
          ro.done = 1'b1;
        end
        MODE_READ: begin
          if (rq.pix < w * h) ro.depth = back_mem[rq.pix];
        end
        default: ;
      endcase
      due_readouts.push_back(ro);
    endfunction

    function void check_result(logic [15:0] depth, logic done);
      readout_t ro;
      if (due_readouts.size() == 0) begin
        errors++;
        $error("unexpected result: back_depth %0d run_done %0d", depth, done);
        return;
      end
      ro = due_readouts.pop_front();
      if (depth !== ro.depth) begin
        errors++;
        $error("back_depth mismatch: expected %0d, actual %0d", ro.depth, depth);
      end
      if (done !== ro.done) begin
        errors++;
        $error("run_done mismatch: expected %0d, actual %0d", ro.done, done);
      end
    endfunction

    function int pending();
      return due_readouts.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [13:0] pixel_index;
  logic [15:0] front_depth;
  logic        is_edge;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] back_depth;
  logic        run_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  depth_scoreboard sb = new();
  int sent_total;
  bit burst;

  depth_back_layer_grow DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .pixel_index(pixel_index),
    .front_depth(front_depth),
    .is_edge(is_edge),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .back_depth(back_depth),
    .run_done(run_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every accepted result is checked against the oldest pending readout.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) sb.check_result(back_depth, run_done);
  end

  // Runaway guard.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side back-pressure. Once, early on, it holds off long enough for the
  // block to fill up and stall its request side.
  initial begin
    int n;
    int r;
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!hold_done && sent_total >= 200) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (299) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_stall <= 1'b0;
          n = $urandom_range(50, 200);
        end else if (r < 55) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 4);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 98) begin
          out_stall <= 1'b1;
          n = $urandom_range(4, 12);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(30, 100);
        end
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Depths lean toward empty and small values so that growth has room and competition.
  function automatic bit [15:0] pick_depth();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 16));
    if (r < 90) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic pix_req_t write_req(int pix, bit [15:0] front, bit seed);
    pix_req_t rq;
    rq.mode = MODE_WRITE;
    rq.pix = 14'(pix);
    rq.front = front;
    rq.seed = seed;
    return rq;
  endfunction

  // Fields a mode does not use still carry random values.
  function automatic pix_req_t plain_req(mode_e m, int pix);
    pix_req_t rq;
    rq.mode = m;
    rq.pix = 14'(pix);
    rq.front = 16'($urandom_range(0, 65535));
    rq.seed = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  function automatic pix_req_t random_fill(int pix);
    return write_req(pix, pick_depth(), $urandom_range(0, 3) == 0);
  endfunction

  // Mostly inside the frame, sometimes anywhere in the index range.
  function automatic int pick_index(int npix);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, npix - 1);
    return $urandom_range(0, STORE_SIZE - 1);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_req(input pix_req_t rq);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= rq.mode;
    pixel_index <= rq.pix;
    front_depth <= rq.front;
    is_edge <= rq.seed;
    do @(posedge clk); while (in_stall);
    sb.note_request(rq);
    sent_total++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every readout is back and the block has settled.
  task automatic go_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no toggle.
  task automatic set_reg(input reg_e idx, input bit [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  // One frame setting: fill every pixel, mix requests, then a final run and readback.
  task automatic grow_phase(input bit [7:0] wv, input bit [7:0] hv, input bit [7:0] pv,
                            input bit poke_unused);
    int npix;
    int count;
    int r;
    int i;
    pix_req_t rq;
    go_idle();
    set_reg(REG_WIDTH, wv);
    set_reg(REG_HEIGHT, hv);
    set_reg(REG_PASSES, pv);
    if (poke_unused) set_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    burst = ($urandom_range(0, 3) == 0);
    npix = sb.frame_pixels();
    for (i = 0; i < npix; i++) send_req(random_fill(i));
    count = $urandom_range(30, 90);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) rq = random_fill(pick_index(npix));
      else if (r < 87) rq = plain_req(MODE_READ, pick_index(npix));
      else if (r < 92) rq = plain_req(MODE_SPARE, $urandom_range(0, STORE_SIZE - 1));
      else rq = plain_req(MODE_RUN, $urandom_range(0, STORE_SIZE - 1));
      send_req(rq);
    end
    send_req(plain_req(MODE_RUN, $urandom_range(0, STORE_SIZE - 1)));
    if (npix <= 100) begin
      for (i = 0; i < npix; i++) send_req(plain_req(MODE_READ, i));
    end else begin
      repeat (40) send_req(plain_req(MODE_READ, $urandom_range(0, npix - 1)));
    end
  endtask

  // Small frames mostly; long pass counts only on tiny frames.
  task automatic random_phase();
    bit [7:0] wv;
    bit [7:0] hv;
    bit [7:0] pv;
    int r;
    int npix;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      wv = 8'($urandom_range(11, 24));
      hv = 8'($urandom_range(0, 4));
    end else if (r == 1) begin
      wv = 8'($urandom_range(0, 4));
      hv = 8'($urandom_range(11, 24));
    end else begin
      wv = 8'($urandom_range(0, 10));
      hv = 8'($urandom_range(0, 10));
    end
    npix = sb.clamp_dim(wv) * sb.clamp_dim(hv);
    if (npix <= 16 && $urandom_range(0, 9) == 0) pv = 8'($urandom_range(7, 255));
    else if (npix > 60) pv = 8'($urandom_range(0, 3));
    else pv = 8'($urandom_range(0, 6));
    grow_phase(wv, hv, pv, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_WRITE;
    pixel_index = '0;
    front_depth = '0;
    is_edge = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    burst = 1'b0;
    sent_total = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset frame of full size: corner pixels, all-ones depth, the unused mode.
    send_req(write_req(0, 16'hFFFF, 1'b1));
    send_req(write_req(STORE_SIZE - 1, 16'h0001, 1'b0));
    send_req(plain_req(MODE_READ, STORE_SIZE - 1));
    send_req(plain_req(MODE_READ, 0));
    send_req(plain_req(MODE_SPARE, $urandom_range(0, STORE_SIZE - 1)));

    // Sizes below the minimum saturate to 3x3; the pass count keeps its reset value.
    // The center seeds its four neighbours, where a deeper front blocks it; the
    // corner seed sits on the border and must not spread.
    go_idle();
    set_reg(REG_WIDTH, 8'd0);
    set_reg(REG_HEIGHT, 8'd1);
    cfg_valid <= 1'b0;
    for (i = 0; i < 9; i++) begin
      if (i == 0) send_req(write_req(i, 16'd50, 1'b1));
      else if (i == 4) send_req(write_req(i, 16'd100, 1'b1));
      else if (i == 5) send_req(write_req(i, 16'd150, 1'b0));
      else if (i == 7) send_req(write_req(i, 16'd60, 1'b0));
      else send_req(write_req(i, 16'd0, 1'b0));
    end
    // Requests just past the frame: the write is dropped and the read gives zero.
    send_req(write_req(9, 16'h1234, 1'b1));
    send_req(plain_req(MODE_READ, 9));
    send_req(plain_req(MODE_RUN, $urandom_range(0, STORE_SIZE - 1)));
    for (i = 0; i < 9; i++) send_req(plain_req(MODE_READ, i));

    // Widest and tallest frames, the longest pass count, and a run with no passes.
    grow_phase(8'd255, 8'd2, 8'd2, 1'b1);
    grow_phase(8'd1, 8'd200, 8'd1, 1'b0);
    grow_phase(8'd3, 8'd3, 8'd255, 1'b0);
    grow_phase(8'd5, 8'd4, 8'd0, 1'b0);

    while (sent_total < REQ_TARGET) random_phase();

    go_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dblg_pkg.sv
rtl/core/dblg_grow.sv
rtl/core/depth_back_layer_grow.sv
tb/depth_back_layer_grow_test.sv
